// File: sv/bfc_pkg.sv
// Shared types and constants for the best-fit free block cache.
package bfc_pkg;

	localparam int SLOTS  = 16;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOC_HIT     = 2'd0,
		ST_ALLOC_MISS    = 2'd1,
		ST_REL_KEPT      = 2'd2,
		ST_REL_NOT_KEPT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} slot_t;

	typedef struct packed {
		logic              apply;
		logic              is_release;
		logic [SIZE_W-1:0] key;
		slot_t             fresh;
	} cell_cmd_t;

endpackage

// File: sv/bfc_if.sv
// Valid/ready channel interfaces for request, response and enable register.
interface bfc_req_if;
	import bfc_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] block_addr;
	logic [SIZE_W-1:0] block_size;
	modport source (output valid, req_type, block_addr, block_size, input ready);
	modport sink (input valid, req_type, block_addr, block_size, output ready);
endinterface

interface bfc_rsp_if;
	import bfc_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] granted_addr;
	logic              evicted_valid;
	logic [ADDR_W-1:0] evicted_addr;
	modport source (output valid, status, granted_addr, evicted_valid, evicted_addr,
		input ready);
	modport sink (input valid, status, granted_addr, evicted_valid, evicted_addr,
		output ready);
endinterface

interface bfc_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: sv/bfc_cell.sv
// One table slot: compares its size against the key and shifts with its neighbors.
module bfc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bfc_pkg::cell_cmd_t        cmd,
	input  bfc_pkg::slot_t            prev_slot,
	input  logic                      prev_flag,
	input  bfc_pkg::slot_t            next_slot,
	input  logic                      next_flag,
	output bfc_pkg::slot_t            slot,
	output logic                      flag,
	output logic [bfc_pkg::ADDR_W-1:0] sel_addr
);
	import bfc_pkg::*;

	slot_t slot_q;

	// release: marks entries smaller than the block; allocate: entries that fit
	assign flag = cmd.is_release ? (slot_q.size < cmd.key) : (slot_q.size >= cmd.key);

	// best fit is the last fitting entry
	assign sel_addr = (!cmd.is_release && flag && !next_flag) ? slot_q.addr : '0;
	assign slot = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.apply) begin
			if (cmd.is_release) begin
				if (flag && !prev_flag) begin
					slot_q <= cmd.fresh;
				end else if (flag) begin
					slot_q <= prev_slot;
				end
			end else if (!next_flag) begin
				slot_q <= next_slot;
			end
		end
	end

endmodule

// File: sv/best_fit_free_block_cache.sv
// Best-fit free block cache: sorted chain of slots with allocate and release.
// The request beat loads the s1 registers; the update cycle then fills the response register.
// A new request is taken once the previous one has updated the table, also while its result waits.
// The update cycle stalls only while the response register is full and not taken.
// Reset (arst_n low) empties every slot and clears the enable register.
module best_fit_free_block_cache (
	input  logic clk,
	input  logic arst_n,
	bfc_cfg_if.sink   cfg,
	bfc_req_if.sink   req,
	bfc_rsp_if.source rsp
);
	import bfc_pkg::*;

	logic              enable_q;
	logic              busy_q;
	logic              type_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [SIZE_W-1:0] size_s1;

	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] granted_q;
	logic              evicted_valid_q;
	logic [ADDR_W-1:0] evicted_addr_q;

	slot_t             slot_w   [SLOTS];
	slot_t             prev_w   [SLOTS];
	slot_t             next_w   [SLOTS];
	logic [SLOTS-1:0]  flag_w;
	logic [SLOTS-1:0]  prev_flag_w;
	logic [SLOTS-1:0]  next_flag_w;
	logic [ADDR_W-1:0] sel_w    [SLOTS];
	logic [ADDR_W-1:0] granted_w;
	logic [SLOTS-1:0]  sel_hit_w;

	cell_cmd_t cmd;
	logic      fire;
	logic      alloc_hit;
	logic      rel_kept;

	assign cfg.ready = 1'b1;
	assign req.ready = !busy_q;

	assign fire      = busy_q && (!rsp_valid_q || rsp.ready);
	assign alloc_hit = enable_q && (type_s1 == REQ_ALLOC) && (size_s1 != '0) && flag_w[0];
	assign rel_kept  = enable_q && (type_s1 == REQ_RELEASE) && (addr_s1 != '0)
		&& flag_w[SLOTS-1];

	always_comb begin
		cmd.apply      = fire && (alloc_hit || rel_kept);
		cmd.is_release = (type_s1 == REQ_RELEASE);
		cmd.key        = size_s1;
		cmd.fresh.addr = addr_s1;
		cmd.fresh.size = size_s1;
	end

	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			if (j == 0) begin
				prev_w[j]      = '0;
				prev_flag_w[j] = 1'b0;
			end else begin
				prev_w[j]      = slot_w[j-1];
				prev_flag_w[j] = flag_w[j-1];
			end
			if (j == SLOTS-1) begin
				next_w[j]      = '0;
				next_flag_w[j] = 1'b0;
			end else begin
				next_w[j]      = slot_w[j+1];
				next_flag_w[j] = flag_w[j+1];
			end
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		bfc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev_slot (prev_w[g]),
			.prev_flag (prev_flag_w[g]),
			.next_slot (next_w[g]),
			.next_flag (next_flag_w[g]),
			.slot      (slot_w[g]),
			.flag      (flag_w[g]),
			.sel_addr  (sel_w[g])
		);
	end

	always_comb begin
		granted_w = '0;
		for (int j = 0; j < SLOTS; j++) begin
			granted_w = granted_w | sel_w[j];
			sel_hit_w[j] = (type_s1 == REQ_ALLOC) && flag_w[j] && !next_flag_w[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			enable_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_s1 <= req.req_type;
			addr_s1 <= req.block_addr;
			size_s1 <= req.block_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			evicted_valid_q <= 1'b0;
			evicted_addr_q  <= '0;
			granted_q       <= '0;
			if (type_s1 == REQ_ALLOC) begin
				status_q <= alloc_hit ? ST_ALLOC_HIT : ST_ALLOC_MISS;
				if (alloc_hit) begin
					granted_q <= granted_w;
				end
			end else begin
				status_q <= rel_kept ? ST_REL_KEPT : ST_REL_NOT_KEPT;
				if (rel_kept && slot_w[SLOTS-1].size != '0) begin
					evicted_valid_q <= 1'b1;
					evicted_addr_q  <= slot_w[SLOTS-1].addr;
				end
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_addr  = granted_q;
	assign rsp.evicted_valid = evicted_valid_q;
	assign rsp.evicted_addr  = evicted_addr_q;

	// table stays sorted: fitting entries form a prefix, smaller entries a suffix
	a_alloc_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && type_s1 == REQ_ALLOC) |-> (((flag_w + 1'b1) & flag_w) == '0))
		else $error("fit flags not a prefix");

	a_release_suffix: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && type_s1 == REQ_RELEASE) |-> (((~flag_w + 1'b1) & ~flag_w) == '0))
		else $error("smaller flags not a suffix");

	a_one_best_fit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(sel_hit_w))
		else $error("more than one best-fit slot");

	a_rsp_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(busy_q))
		else $error("response without an update cycle");

endmodule

// File: tb/bfc_checker.sv
`timescale 1ns / 100ps
// Checker for the free block cache: predicts each response from request beats and compares.
module bfc_checker
	import bfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bfc_cfg_if   cfg,
	bfc_req_if   req,
	bfc_rsp_if   rsp,
	output int   error_count,
	output int   results_seen,
	output int   alloc_hits,
	output int   releases_kept,
	output int   evictions
);

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted;
		logic              evict_v;
		logic [ADDR_W-1:0] evict_addr;
	} outcome_t;

	logic [ADDR_W-1:0] free_addr [SLOTS];
	logic [SIZE_W-1:0] free_size [SLOTS];
	logic              enabled;
	outcome_t          pending_q [$];

	// best fit on allocate, sorted insert on release; updates the shadow table
	function automatic outcome_t serve_request(logic rtype, logic [ADDR_W-1:0] addr,
		logic [SIZE_W-1:0] size);
		outcome_t o;
		int       pos;
		int       i;
		o = '0;
		pos = -1;
		if (rtype == REQ_ALLOC) begin
			o.status = ST_ALLOC_MISS;
			if (enabled && size != '0) begin
				for (i = SLOTS - 1; i >= 0; i--)
					if (pos < 0 && free_size[i] >= size)
						pos = i;
				if (pos >= 0) begin
					o.status = ST_ALLOC_HIT;
					o.granted = free_addr[pos];
					for (i = pos; i < SLOTS - 1; i++) begin
						free_addr[i] = free_addr[i + 1];
						free_size[i] = free_size[i + 1];
					end
					free_addr[SLOTS - 1] = '0;
					free_size[SLOTS - 1] = '0;
				end
			end
		end else begin
			o.status = ST_REL_NOT_KEPT;
			if (enabled && addr != '0) begin
				for (i = 0; i < SLOTS; i++)
					if (pos < 0 && free_size[i] < size)
						pos = i;
				if (pos >= 0) begin
					if (free_size[SLOTS - 1] != '0) begin
						o.evict_v = 1'b1;
						o.evict_addr = free_addr[SLOTS - 1];
					end
					for (i = SLOTS - 1; i > pos; i--) begin
						free_addr[i] = free_addr[i - 1];
						free_size[i] = free_size[i - 1];
					end
					free_addr[pos] = addr;
					free_size[pos] = size;
					o.status = ST_REL_KEPT;
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				free_addr[i] = '0;
				free_size[i] = '0;
			end
			enabled = 1'b0;
			pending_q.delete();
			error_count = 0;
			results_seen = 0;
			alloc_hits = 0;
			releases_kept = 0;
			evictions = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				enabled = cfg.data;
			if (rsp.valid && rsp.ready) begin
				got.status = status_t'(rsp.status);
				got.granted = rsp.granted_addr;
				got.evict_v = rsp.evicted_valid;
				got.evict_addr = rsp.evicted_addr;
				results_seen++;
				if (pending_q.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: response beat %0d with nothing pending: status %0d granted %h evict %b %h",
							$realtime, results_seen, got.status, got.granted, got.evict_v,
							got.evict_addr);
				end else begin
					want = pending_q.pop_front();
					if (want.status == ST_ALLOC_HIT)
						alloc_hits++;
					if (want.status == ST_REL_KEPT)
						releases_kept++;
					if (want.evict_v)
						evictions++;
					if (got !== want) begin
						error_count++;
						if (error_count <= 10)
							$display("%0t: response %0d expected status %0d granted %h evict %b %h, got status %0d granted %h evict %b %h",
								$realtime, results_seen, want.status, want.granted, want.evict_v,
								want.evict_addr, got.status, got.granted, got.evict_v,
								got.evict_addr);
					end
				end
			end
			if (req.valid && req.ready)
				pending_q.push_back(serve_request(req.req_type, req.block_addr, req.block_size));
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the free block cache testbench: clock, reset, stimulus and verdict.
module tb;
	import bfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int error_count;
	int results_seen;
	int alloc_hits;
	int releases_kept;
	int evictions;
	int items_sent = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int release_pct = 50;
	int quiet_cycles = 0;

	bfc_cfg_if cfg_ch ();
	bfc_req_if req_ch ();
	bfc_rsp_if rsp_ch ();

	best_fit_free_block_cache uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bfc_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_ch),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.error_count   (error_count),
		.results_seen  (results_seen),
		.alloc_hits    (alloc_hits),
		.releases_kept (releases_kept),
		.evictions     (evictions)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_item(logic rtype, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.block_addr <= addr;
		req_ch.block_size <= size;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(logic value);
		wait_all_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly small sizes so allocates find fits; some zero, all-ones and full-range
	task automatic send_random();
		logic              rtype;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		rtype = ($urandom_range(99) < release_pct) ? REQ_RELEASE : REQ_ALLOC;
		addr = $urandom();
		if ($urandom_range(31) == 0)
			addr = '0;
		case ($urandom_range(15))
			0: size = '0;
			1: size = '1;
			2, 3: size = $urandom();
			default: size = $urandom_range(64, 1);
		endcase
		send_item(rtype, addr, size);
	endtask

	task automatic run_phase(int src_pct, int sink_pct, int count);
		int n;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (n = 0; n < count; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(2))
					0: release_pct = 30;
					1: release_pct = 50;
					default: release_pct = 80;
				endcase
			end
			send_random();
		end
		wait_all_results();
	endtask

	initial begin
		int k;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_ALLOC;
		req_ch.block_addr <= '0;
		req_ch.block_size <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: everything passes through
		send_item(REQ_ALLOC, 32'h0, 32'd5);
		send_item(REQ_RELEASE, 32'h100, 32'd8);
		write_enable(1'b1);

		send_item(REQ_ALLOC, 32'h0, 32'd0);
		send_item(REQ_ALLOC, 32'h0, '1);
		send_item(REQ_RELEASE, 32'h0, 32'd40);
		send_item(REQ_RELEASE, 32'h1234, 32'd0);
		send_item(REQ_RELEASE, '1, '1);
		send_item(REQ_RELEASE, 32'h1, 32'd1);
		for (k = 0; k < SLOTS - 2; k++)
			send_item(REQ_RELEASE, 32'h1000 + k * 16, 100 + k);
		// table full: insert evicts the smallest, equal or smaller is dropped
		send_item(REQ_RELEASE, 32'h2000, 32'd2);
		send_item(REQ_RELEASE, 32'h2100, 32'd1);
		send_item(REQ_RELEASE, 32'h2200, 32'd2);
		send_item(REQ_ALLOC, 32'h0, '1);
		send_item(REQ_ALLOC, 32'h0, 32'd3);
		send_item(REQ_ALLOC, 32'h0, 32'h8000_0000);
		send_item(REQ_ALLOC, 32'h0, 32'd0);
		wait_all_results();

		run_phase(0, 0, 300);
		run_phase(56, 0, 300);
		write_enable(1'b0);
		run_phase(0, 56, 100);
		write_enable(1'b1);
		run_phase(0, 56, 300);
		run_phase(8, 8, 500);

		$display("covered %0d requests in five idling phases, cache toggled off and on",
			items_sent);
		$display("responses %0d: %0d allocate hits, %0d releases kept, %0d evictions",
			results_seen, alloc_hits, releases_kept, evictions);
		if (error_count == 0 && results_seen == items_sent)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
